// ===== hw/rtl/drft_pkg.sv =====
`default_nettype none

package drft_pkg;

  localparam int RING_BYTES_LOG2_DEF  = 19;
  localparam int CHUNK_BYTES_LOG2_DEF = 16;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int WP_W     = 32;
  localparam int AVAIL_W  = 3;
  localparam int BUDGET_W = 11;
  localparam int THR_W    = 24;
  localparam int WORD_W   = 22;
  localparam int CAP_W    = 16;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX   = 11'd1024;
  localparam logic [BUDGET_W-1:0] BUDGET_MIN   = 11'd64;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 11'd256;

  localparam logic [THR_W-1:0] TMIN_RESET = 24'd65536;
  localparam logic [THR_W-1:0] TMAX_RESET = 24'd262144;

  localparam logic [CAP_W-1:0]  WORD_CAP   = 16'hFFFF;
  localparam int                IRQ_EN_BIT = 21;
  localparam logic [WORD_W-1:0] IRQ_ENABLE = WORD_W'(1) << IRQ_EN_BIT;

  localparam int PCT_SCALE = 100;
  localparam int BAND_HI   = 76;
  localparam int BAND_MID  = 51;
  localparam int BAND_LO   = 26;

  typedef enum logic [1:0] {
    OP_WRITE_PTR = 2'd0,
    OP_READ_FAIL = 2'd1,
    OP_CONSUME   = 2'd2,
    OP_ROUND_END = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_RING_BASE = 2'd0,
    REG_TMIN      = 2'd1,
    REG_TMAX      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [WP_W-1:0] write_pointer;
    logic            source_invalid;
  } evt_t;

  typedef struct packed {
    logic [AVAIL_W-1:0]  chunks_available;
    logic                consumed;
    logic                backpressure;
    logic [BUDGET_W-1:0] budget_now;
    logic [THR_W-1:0]    threshold_now;
    logic                threshold_write;
    logic [WORD_W-1:0]   threshold_word;
    logic                requeue;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drft_stream_if.sv =====
`default_nettype none

interface drft_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dma_ring_fill_tracker_adaptive_irq_core.sv =====
// Channel   Dir  Payload                                   Transfer
// events    in   evt_t: operation, write_pointer, invalid  valid & ready
// status    out  result_t: fill, budget, threshold, word   valid & ready
// apb       in   psel/penable/pwrite/paddr/pwdata/prdata   psel & penable & pwrite
//
// One event per cycle while events.ready is high; its result is registered.
// Rate is set by the single combinational pass from the state registers to the result register.
// A two-entry output stage (result plus skid) keeps events flowing while status stalls.
// events.ready drops only when both output entries are full.
// rst is synchronous, active high; no clearing pass is needed.
`default_nettype none

module dma_ring_fill_tracker_adaptive_irq_core
  import drft_pkg::*;
#(
  parameter int RING_BYTES_LOG2  = RING_BYTES_LOG2_DEF,
  parameter int CHUNK_BYTES_LOG2 = CHUNK_BYTES_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  drft_stream_if.sink       events,
  drft_stream_if.source     status
);

  localparam int ENTRIES_LOG2 = RING_BYTES_LOG2 - CHUNK_BYTES_LOG2;
  localparam int IW           = (ENTRIES_LOG2 > 0) ? ENTRIES_LOG2 : 1;
  localparam int PW           = IW + 7;
  localparam longint ENTRIES  = 64'd1 << ENTRIES_LOG2;

  localparam logic [IW-1:0] ENTRY_MASK = IW'(ENTRIES - 64'd1);
  localparam logic [IW-1:0] BP_LEVEL   = IW'((ENTRIES * 3) / 4);
  localparam logic [PW-1:0] PCT_HI     = PW'(ENTRIES * BAND_HI);
  localparam logic [PW-1:0] PCT_MID    = PW'(ENTRIES * BAND_MID);
  localparam logic [PW-1:0] PCT_LO     = PW'(ENTRIES * BAND_LO);

  logic [WP_W-1:0]     ring_base;
  logic [THR_W-1:0]    thr_min;
  logic [THR_W-1:0]    thr_max;

  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [IW-1:0]       last_chunk;
  logic [BUDGET_W-1:0] budget;
  logic [THR_W-1:0]    cur_thr;
  logic [BUDGET_W-1:0] round_iter;
  logic [BUDGET_W-1:0] round_work;

  logic [IW-1:0]       head_next;
  logic [IW-1:0]       tail_next;
  logic [IW-1:0]       last_chunk_next;
  logic [BUDGET_W-1:0] budget_next;
  logic [THR_W-1:0]    cur_thr_next;
  logic [BUDGET_W-1:0] round_iter_next;
  logic [BUDGET_W-1:0] round_work_next;

  result_t             res_q;
  result_t             skid_q;
  result_t             res_new;
  logic                res_valid;
  logic                skid_valid;

  evt_t                evt;
  op_t                 op;
  logic                accept;
  logic                pop;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  logic [WP_W-1:0]     wp_diff;
  logic [IW-1:0]       chunk;
  logic [IW-1:0]       delta_raw;
  logic [IW-1:0]       delta;
  logic [IW-1:0]       fill_cur;
  logic [IW-1:0]       fill_next;
  logic [31:0]         fill_wide;
  logic [PW-1:0]       fill_x100;
  logic                can_consume;

  logic [BUDGET_W-1:0] budget_half;
  logic [BUDGET_W:0]   budget_dbl;
  logic [BUDGET_W-1:0] budget_up;
  logic [BUDGET_W-1:0] budget_dn;
  logic [BUDGET_W-1:0] budget_adapt;

  logic [THR_W:0]      thr_pick;
  logic [THR_W-1:0]    thr_clamped;
  logic [CAP_W-1:0]    word_capped;

  logic                consumed;
  logic                twrite;
  logic                requeue;

  assign evt     = events.data;
  assign op      = op_t'(evt.operation);
  assign accept  = events.valid && events.ready;
  assign pop     = res_valid && status.ready;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_RING_BASE: prdata = ring_base;
      REG_TMIN:      prdata = DATA_W'(thr_min);
      REG_TMAX:      prdata = DATA_W'(thr_max);
      default:       prdata = '0;
    endcase
  end

  assign wp_diff     = evt.write_pointer - ring_base;
  assign chunk       = IW'(wp_diff >> CHUNK_BYTES_LOG2) & ENTRY_MASK;
  assign delta_raw   = (chunk - last_chunk) & ENTRY_MASK;
  assign delta       = (delta_raw == '0) ? IW'(1) : delta_raw;
  assign fill_cur    = (head - tail) & ENTRY_MASK;
  assign can_consume = (round_iter < budget) && (fill_cur != '0);

  assign budget_half = budget >> 1;
  assign budget_dbl  = {budget, 1'b0};
  assign budget_up   = (budget_dbl > (BUDGET_W+1)'(BUDGET_MAX)) ? BUDGET_MAX
                                                                 : budget_dbl[BUDGET_W-1:0];
  assign budget_dn   = (budget_half < BUDGET_MIN) ? BUDGET_MIN : budget_half;

  always_comb begin
    if (round_work >= budget_half) begin
      budget_adapt = budget_up;
    end else if (round_work == '0) begin
      budget_adapt = budget_dn;
    end else begin
      budget_adapt = budget;
    end
  end

  // fill percent bands, compared without dividing: pct > k  <=>  fill*100 >= (k+1)*entries
  assign fill_x100 = PW'(fill_cur) * PW'(PCT_SCALE);

  always_comb begin
    if (fill_x100 >= PCT_HI) begin
      thr_pick = {1'b0, thr_max};
    end else if (fill_x100 >= PCT_MID) begin
      thr_pick = {thr_min, 1'b0};
    end else if (fill_x100 >= PCT_LO) begin
      thr_pick = {1'b0, thr_min};
    end else begin
      thr_pick = {2'b00, thr_min[THR_W-1:1]};
    end
    if (thr_pick >= {1'b0, thr_max}) begin
      thr_clamped = thr_max;
    end else if (thr_pick <= {1'b0, thr_min}) begin
      thr_clamped = thr_min;
    end else begin
      thr_clamped = thr_pick[THR_W-1:0];
    end
  end

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    last_chunk_next = last_chunk;
    budget_next     = budget;
    cur_thr_next    = cur_thr;
    round_iter_next = round_iter;
    round_work_next = round_work;
    consumed        = 1'b0;
    twrite          = 1'b0;
    requeue         = 1'b0;
    case (op)
      OP_WRITE_PTR: begin
        last_chunk_next = chunk;
        head_next       = (head + delta) & ENTRY_MASK;
      end
      OP_READ_FAIL: begin
        head_next = (head + IW'(1)) & ENTRY_MASK;
      end
      OP_CONSUME: begin
        if (can_consume) begin
          round_iter_next = round_iter + BUDGET_W'(1);
          tail_next       = (tail + IW'(1)) & ENTRY_MASK;
          consumed        = 1'b1;
          if (!evt.source_invalid) begin
            round_work_next = round_work + BUDGET_W'(1);
          end
        end
      end
      OP_ROUND_END: begin
        budget_next = budget_adapt;
        if (thr_clamped != cur_thr) begin
          cur_thr_next = thr_clamped;
          twrite       = 1'b1;
        end
        round_iter_next = '0;
        round_work_next = '0;
        requeue         = (fill_cur != '0);
      end
      default: begin
      end
    endcase
  end

  assign fill_next   = (head_next - tail_next) & ENTRY_MASK;
  assign fill_wide   = 32'(fill_next);
  assign word_capped = cur_thr_next[THR_W-1] ? WORD_CAP : cur_thr_next[THR_W-2:7];

  always_comb begin
    res_new.chunks_available = fill_wide[AVAIL_W-1:0];
    res_new.consumed         = consumed;
    res_new.backpressure     = (fill_next >= BP_LEVEL);
    res_new.budget_now       = budget_next;
    res_new.threshold_now    = cur_thr_next;
    res_new.threshold_write  = twrite;
    res_new.threshold_word   = IRQ_ENABLE | WORD_W'(word_capped);
    res_new.requeue          = requeue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
      thr_min   <= TMIN_RESET;
      thr_max   <= TMAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RING_BASE: ring_base <= pwdata;
        REG_TMIN:      thr_min   <= pwdata[THR_W-1:0];
        REG_TMAX:      thr_max   <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      last_chunk <= '0;
      budget     <= BUDGET_RESET;
      cur_thr    <= TMIN_RESET;
      round_iter <= '0;
      round_work <= '0;
    end else if (accept) begin
      head       <= head_next;
      tail       <= tail_next;
      last_chunk <= last_chunk_next;
      budget     <= budget_next;
      cur_thr    <= cur_thr_next;
      round_iter <= round_iter_next;
      round_work <= round_work_next;
    end
  end

  // output stage: result register plus skid entry
  assign events.ready = !skid_valid;
  assign status.valid = res_valid;
  assign status.data  = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!res_valid || pop) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!res_valid || pop) begin
        res_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end else if (pop) begin
      res_q <= skid_q;
    end
  end

`ifndef SYNTH
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry holds a result while the result register is empty");

  a_iter_within_budget: assert property (@(posedge clk) disable iff (rst)
    round_iter <= budget)
    else $error("round iterations exceed poll budget");

  a_work_within_iter: assert property (@(posedge clk) disable iff (rst)
    round_work <= round_iter)
    else $error("round work exceeds round iterations");

  a_budget_range: assert property (@(posedge clk) disable iff (rst)
    (budget >= BUDGET_MIN) && (budget <= BUDGET_MAX))
    else $error("poll budget out of range");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import drft_pkg::*;

  localparam int ENT_LOG2 = RING_BYTES_LOG2_DEF - CHUNK_BYTES_LOG2_DEF;
  localparam int ENTRIES = 1 << ENT_LOG2;
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 144;
  localparam int LIMIT = 400000;

  typedef logic [ENT_LOG2-1:0] idx_t;

  class status_board;
    idx_t head, tail, last_chunk;
    int unsigned budget, iters, work;
    logic [THR_W-1:0] thr, tmin, tmax;
    logic [31:0] base;
    result_t due[$];
    int unsigned errors;

    function new();
      head = '0;
      tail = '0;
      last_chunk = '0;
      budget = BUDGET_RESET;
      iters = 0;
      work = 0;
      thr = TMIN_RESET;
      tmin = TMIN_RESET;
      tmax = TMAX_RESET;
      base = '0;
      errors = 0;
    endfunction

    function idx_t fill();
      return head - tail;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void write_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_RING_BASE: base = v;
        REG_TMIN: tmin = v[THR_W-1:0];
        REG_TMAX: tmax = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [THR_W-1:0] band_threshold();
      int unsigned pct;
      logic [31:0] t;
      pct = int'(fill()) * PCT_SCALE / ENTRIES;
      if (pct >= BAND_HI) begin
        t = 32'(tmax);
      end else if (pct >= BAND_MID) begin
        t = 32'(tmin) << 1;
      end else if (pct >= BAND_LO) begin
        t = 32'(tmin);
      end else begin
        t = 32'(tmin) >> 1;
      end
      if (t >= 32'(tmax)) return tmax;
      if (t <= 32'(tmin)) return tmin;
      return t[THR_W-1:0];
    endfunction

    function void note_request(evt_t r);
      result_t e;
      logic [31:0] off;
      idx_t chunk, step;
      logic [THR_W-1:0] t, q;
      e = '0;
      case (op_t'(r.operation))
        OP_WRITE_PTR: begin
          off = r.write_pointer - base;
          chunk = off[RING_BYTES_LOG2_DEF-1:CHUNK_BYTES_LOG2_DEF];
          step = chunk - last_chunk;
          if (step == '0) step = 1;
          last_chunk = chunk;
          head = head + step;
        end
        OP_READ_FAIL: head = head + 1'b1;
        OP_CONSUME: begin
          if (iters < budget && fill() != '0) begin
            iters++;
            tail = tail + 1'b1;
            e.consumed = 1'b1;
            if (!r.source_invalid) work++;
          end
        end
        OP_ROUND_END: begin
          if (work >= budget / 2) begin
            budget = budget * 2;
            if (budget > BUDGET_MAX) budget = BUDGET_MAX;
          end else if (work == 0) begin
            budget = budget / 2;
            if (budget < BUDGET_MIN) budget = BUDGET_MIN;
          end
          t = band_threshold();
          if (t != thr) begin
            thr = t;
            e.threshold_write = 1'b1;
          end
          iters = 0;
          work = 0;
          e.requeue = (fill() != '0);
        end
        default: ;
      endcase
      e.chunks_available = AVAIL_W'(fill());
      e.backpressure = (int'(fill()) >= ENTRIES * 3 / 4);
      e.budget_now = BUDGET_W'(budget);
      e.threshold_now = thr;
      q = thr >> 7;
      if (q > THR_W'(WORD_CAP)) q = THR_W'(WORD_CAP);
      e.threshold_word = IRQ_ENABLE | WORD_W'(q);
      due.push_back(e);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("status with no request pending: 0x%0h", got);
        errors++;
        return;
      end
      want = due.pop_front();
      cmp_field("chunks_available", want.chunks_available, got.chunks_available);
      cmp_field("consumed", want.consumed, got.consumed);
      cmp_field("backpressure", want.backpressure, got.backpressure);
      cmp_field("budget_now", want.budget_now, got.budget_now);
      cmp_field("threshold_now", want.threshold_now, got.threshold_now);
      cmp_field("threshold_write", want.threshold_write, got.threshold_write);
      cmp_field("threshold_word", want.threshold_word, got.threshold_word);
      cmp_field("requeue", want.requeue, got.requeue);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  drft_stream_if #(.T(evt_t)) ev_if ();
  drft_stream_if #(.T(result_t)) st_if ();

  dma_ring_fill_tracker_adaptive_irq_core i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .events(ev_if),
    .status(st_if)
  );

  status_board sb;
  bit idle_on = 1'b1;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // status stall bursts, with occasional calm stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      st_if.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      st_if.ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      st_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 30) == 0) calm_left <= $urandom_range(20, 120);
      st_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && st_if.valid && st_if.ready) sb.check_status(st_if.data);
  end

  task automatic send_req(op_t op, logic [31:0] wp, logic inv);
    evt_t r;
    r.operation = op;
    r.write_pointer = wp;
    r.source_invalid = inv;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    ev_if.valid <= 1'b1;
    ev_if.data <= r;
    do @(posedge clk); while (!ev_if.ready);
    sb.note_request(r);
    sent++;
  endtask

  function automatic logic [31:0] ptr_to(idx_t chunk);
    logic [31:0] off;
    off = $urandom;
    off[RING_BYTES_LOG2_DEF-1:CHUNK_BYTES_LOG2_DEF] = chunk;
    return sb.base + off;
  endfunction

  task automatic advance_head(int unsigned delta);
    send_req(OP_WRITE_PTR, ptr_to(sb.last_chunk + idx_t'(delta)), 1'($urandom));
  endtask

  task automatic refill();
    if ($urandom_range(0, 3) == 0) begin
      send_req(OP_READ_FAIL, $urandom, 1'($urandom));
    end else begin
      advance_head($urandom_range(0, ENTRIES - 1));
    end
  endtask

  task automatic drain();
    ev_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write, then read back
  task automatic reg_write(reg_idx_t r, logic [31:0] v);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(32'(r) << 2);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(r, v);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = (r == REG_RING_BASE) ? v : {8'h00, v[THR_W-1:0]};
    if (prdata !== want) begin
      $error("prdata: expected 0x%0h, actual 0x%0h", want, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int p);
    logic [31:0] b, junk;
    logic [THR_W-1:0] lo, hi;
    junk = $urandom;
    case (p)
      0: begin
        b = '0;
        lo = 1;
        hi = '1;
      end
      1: begin
        b = '1;
        lo = '1;
        hi = 1;
      end
      2: begin
        b = $urandom;
        lo = TMIN_RESET;
        hi = TMAX_RESET;
      end
      3: begin
        b = $urandom;
        lo = $urandom_range(1, 4096);
        hi = $urandom_range(1 << 16, (1 << THR_W) - 1);
      end
      default: begin
        b = $urandom;
        lo = $urandom_range(1, (1 << THR_W) - 1);
        hi = $urandom_range(1, (1 << THR_W) - 1);
      end
    endcase
    reg_write(REG_RING_BASE, b);
    reg_write(REG_TMIN, {junk[7:0], lo});
    reg_write(REG_TMAX, {junk[15:8], hi});
  endtask

  task automatic run_round();
    int unsigned kind, sel, n;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(0, 3);
      repeat (n) refill();
    end else if (kind < 5) begin
      n = $urandom_range(1, 12);
      repeat (n) send_req(op_t'($urandom_range(0, 3)), $urandom, 1'($urandom));
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 6 || sb.budget > 512) begin
        n = $urandom_range(1, 20);
      end else if (sel < 9 || sb.budget > 128) begin
        n = sb.budget / 2 + $urandom_range(0, 4);
      end else begin
        n = sb.budget + $urandom_range(1, 6);
      end
      repeat (n) begin
        if (sb.fill() == '0 || $urandom_range(0, 7) == 0) refill();
        send_req(OP_CONSUME, $urandom, $urandom_range(0, 3) == 0);
      end
    end
    send_req(OP_ROUND_END, $urandom, 1'($urandom));
  endtask

  initial begin
    int unsigned first;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ev_if.valid = 1'b0;
    ev_if.data = '0;
    st_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: round end halves budget, consume retires nothing
    send_req(OP_ROUND_END, 32'h0, 1'b0);
    send_req(OP_CONSUME, 32'hFFFF_FFFF, 1'b0);
    // same chunk still advances by one
    send_req(OP_WRITE_PTR, 32'h0, 1'b0);
    // wrap by seven: full ring reads as empty
    send_req(OP_WRITE_PTR, 32'hFFFF_FFFF, 1'b1);
    send_req(OP_READ_FAIL, 32'hFFFF_FFFF, 1'b1);
    advance_head(ENTRIES - 2);
    // top band, backpressure, budget to floor
    send_req(OP_ROUND_END, 32'h0, 1'b0);
    send_req(OP_ROUND_END, 32'h0, 1'b1);
    send_req(OP_CONSUME, 32'h0, 1'b1);
    send_req(OP_CONSUME, 32'h0, 1'b0);
    send_req(OP_ROUND_END, 32'h0, 1'b0);
    send_req(OP_CONSUME, 32'h0, 1'b0);
    send_req(OP_CONSUME, 32'h0, 1'b0);
    send_req(OP_ROUND_END, 32'h0, 1'b0);
    send_req(OP_CONSUME, 32'h0, 1'b0);
    send_req(OP_CONSUME, 32'h0, 1'b1);
    send_req(OP_ROUND_END, 32'h0, 1'b0);
    send_req(OP_WRITE_PTR, 32'h0007_FFFF, 1'b0);
    send_req(OP_CONSUME, 32'h0, 1'b0);
    send_req(OP_ROUND_END, 32'hFFFF_FFFF, 1'b1);
    first = sent;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(p);
      idle_on = (p < PHASES - 1);
      while (sent < first + (p + 1) * PHASE_REQS) run_round();
    end
    drain();

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
